// File: rtl/core/asfr_pkg.sv
// ----------------------------------------------------------------------------
// asfr_pkg: shared types for the air sensor frame receiver
// Frame status codes, the reset header value and the record types that pass
// between the frame collector and the top level.
// ----------------------------------------------------------------------------
package asfr_pkg;

  // frame status codes, in order of check priority from last to first
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SUM    = 2'd1,
    ST_HEADER = 2'd2,
    ST_LENGTH = 2'd3
  } status_t;

  // expected first byte of a frame after reset
  localparam logic [7:0] HEADER_RESET = 8'h5F;

  // one accepted request as seen by the collector
  typedef struct packed {
    logic       take_byte;
    logic       take_idle;
    logic [7:0] data;
  } coll_req_t;

  // frame check outcome, meaningful when an idle event is taken
  typedef struct packed {
    status_t     status;
    logic [15:0] voc;
    logic [15:0] formaldehyde;
    logic [15:0] co2;
  } frame_res_t;

endpackage

// File: rtl/core/asfr_ifs.sv
// ----------------------------------------------------------------------------
// asfr interfaces: request and result channels
// Valid/ready channels; a transfer happens on a rising edge with both high.
// ----------------------------------------------------------------------------
interface asfr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink (input valid, command, rx_byte, output ready);
endinterface

interface asfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [15:0] voc_raw;
  logic [15:0] formaldehyde_raw;
  logic [15:0] co2_raw;

  modport source (output valid, frame_status, voc_raw, formaldehyde_raw, co2_raw,
                  input ready);
  modport sink (input valid, frame_status, voc_raw, formaldehyde_raw, co2_raw,
                output ready);
endinterface

// File: rtl/core/air_sensor_frame_receiver.sv
// ----------------------------------------------------------------------------
// air_sensor_frame_receiver: sensor frame parser with sum checksum
// Collects UART bytes into a frame and reports status and three readings
// each time the line goes idle.
//
// Usage:
//   in_req  : requests; command 0 carries a received byte, command 1 marks
//             line idle and ends the frame.
//   out_res : one result per idle request: status (ok, checksum, header,
//             length) and VOC, formaldehyde and CO2 raw readings.
//   cfg_we / cfg_wdata : header byte register, written while idle.
// Result: registered, and valid in the cycle after its idle request is taken.
// Throughput: one request per cycle while no result stalls; the single output
//   register holds a result; the next request is taken in the cycle it drains.
// Reset: byte count and running sum clear, header returns to 0x5F, no
//   result pending.
// Stall: while a result waits and out_res.ready is low, in_req.ready is
//   low; byte store and count hold.
// ----------------------------------------------------------------------------
module air_sensor_frame_receiver
  import asfr_pkg::*;
#(
  parameter int FRAME_LEN = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  asfr_in_if.sink    in_req,
  asfr_out_if.source out_res,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic        idle_taken;
  logic [7:0]  hdr_r;
  logic        advance;
  logic        accept;
  coll_req_t   creq;
  frame_res_t  cres;
  logic        out_vld_r;
  logic        out_vld_nxt;
  frame_res_t  out_res_r;

  // header register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= HEADER_RESET;
    end else if (cfg_we) begin
      hdr_r <= cfg_wdata;
    end
  end

  // request handshake: take a request when the result slot is free or drains
  assign advance      = !out_vld_r || out_res.ready;
  assign in_req.ready = advance;
  assign accept       = in_req.valid && advance;

  assign creq.take_byte = accept && !in_req.command;
  assign creq.take_idle = accept && in_req.command;
  assign creq.data      = in_req.rx_byte;
  assign idle_taken     = creq.take_idle;

  asfr_collector #(
    .FRAME_LEN(FRAME_LEN)
  ) u_coll (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .header(hdr_r),
    .res   (cres)
  );

  // result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (idle_taken) begin
      out_vld_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (idle_taken) begin
      out_res_r <= cres;
    end
  end

  assign out_res.valid            = out_vld_r;
  assign out_res.frame_status     = out_res_r.status;
  assign out_res.voc_raw          = out_res_r.voc;
  assign out_res.formaldehyde_raw = out_res_r.formaldehyde;
  assign out_res.co2_raw          = out_res_r.co2;

`ifndef ASSERT_OFF
  // an idle request always yields a pending result next cycle
  a_idle_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready && in_req.command) |=> out_res.valid)
    else $error("idle request produced no result");

  // a new result only follows an idle request
  a_result_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_res.valid) |-> $past(in_req.valid && in_req.ready && in_req.command))
    else $error("result without idle request");

  // readings are zero whenever the frame failed a check
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.frame_status != ST_OK) |->
      (out_res.voc_raw == '0 && out_res.formaldehyde_raw == '0 &&
       out_res.co2_raw == '0))
    else $error("nonzero reading on failed frame");

  // no request is taken while a stalled result waits
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.ready) |-> !in_req.ready)
    else $error("request taken over a stalled result");
`endif

endmodule

// File: rtl/core/asfr_collector.sv
// ----------------------------------------------------------------------------
// asfr_collector: frame byte store and frame checker
// Stores each byte at the running count, keeps a running modulo-256 sum of
// the header and data bytes, and checks length, header and checksum on idle.
// ----------------------------------------------------------------------------
module asfr_collector
  import asfr_pkg::*;
#(
  parameter int FRAME_LEN = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  coll_req_t  req,
  input  logic [7:0] header,
  output frame_res_t res
);

  localparam int CW = $clog2(FRAME_LEN + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(FRAME_LEN);
  localparam logic [CW-1:0] CNT_SUM  = CW'(FRAME_LEN - 1);

  logic [7:0]    frame_r [FRAME_LEN];
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [7:0]    sum_r;
  logic [7:0]    sum_nxt;
  logic [7:0]    rd_byte [1:6];
  status_t       status;

  // byte store, written at the current count; overflow byte is dropped
  always_ff @(posedge clk) begin
    for (int k = 0; k < FRAME_LEN; k++) begin
      if (req.take_byte && count_r == CW'(k)) begin
        frame_r[k] <= req.data;
      end
    end
  end

  // count and running sum of the bytes ahead of the checksum byte
  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (req.take_idle) begin
      count_nxt = '0;
      sum_nxt   = '0;
    end else if (req.take_byte) begin
      if (count_r == CNT_FULL) begin
        count_nxt = '0;
        sum_nxt   = '0;
      end else begin
        count_nxt = count_r + 1'b1;
        if (count_r < CNT_SUM) begin
          sum_nxt = sum_r + req.data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // reading bytes; a position at or past the checksum byte reads as zero
  for (genvar g = 1; g <= 6; g++) begin : g_rd
    if (g < FRAME_LEN - 1) begin : g_on
      assign rd_byte[g] = frame_r[g];
    end else begin : g_off
      assign rd_byte[g] = '0;
    end
  end

  // checks in priority order: length, header, checksum
  always_comb begin
    if (count_r != CNT_FULL) begin
      status = ST_LENGTH;
    end else if (frame_r[0] != header) begin
      status = ST_HEADER;
    end else if (sum_r != frame_r[FRAME_LEN-1]) begin
      status = ST_SUM;
    end else begin
      status = ST_OK;
    end
  end

  // readings are zeroed on any error
  always_comb begin
    res.status = status;
    if (status == ST_OK) begin
      res.voc          = {rd_byte[1], rd_byte[2]};
      res.formaldehyde = {rd_byte[3], rd_byte[4]};
      res.co2          = {rd_byte[5], rd_byte[6]};
    end else begin
      res.voc          = '0;
      res.formaldehyde = '0;
      res.co2          = '0;
    end
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: air sensor frame receiver
// Sends byte and line-idle requests in bursts and checks every frame result
// against a frame tracker kept alongside the block. A short table of
// directed frames comes first: an empty frame, a good frame, a checksum error
// with extreme bytes and a header error. Random frames follow under several
// header settings, including both extremes. The result side stalls on a
// rotating pattern.
// ----------------------------------------------------------------------------
module testbench;
  import asfr_pkg::*;

  localparam int FRAME_LEN = 8;
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_IDLE = 1'b1;
  localparam int PHASE_REQUESTS = 105;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
    logic       typed;
    frame_res_t want;
  } stim_row_t;

  localparam frame_res_t NO_RESULT = '0;

  // directed frames; idle rows carry the result that can be read off directly
  localparam stim_row_t DIRECTED [28] = '{
    '{CMD_IDLE, 8'h00, 1'b1, '{ST_LENGTH, 16'h0000, 16'h0000, 16'h0000}},
    '{CMD_BYTE, 8'h5F, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'h12, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'h34, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'h56, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'h78, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'h9A, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'hBC, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'hC9, 1'b0, NO_RESULT},
    '{CMD_IDLE, 8'h00, 1'b1, '{ST_OK, 16'h1234, 16'h5678, 16'h9ABC}},
    '{CMD_BYTE, 8'h5F, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'hFF, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'hFF, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'hFF, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'hFF, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'hFF, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'hFF, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{CMD_IDLE, 8'h00, 1'b1, '{ST_SUM, 16'h0000, 16'h0000, 16'h0000}},
    '{CMD_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{CMD_BYTE, 8'h00, 1'b0, NO_RESULT},
    '{CMD_IDLE, 8'hFF, 1'b1, '{ST_HEADER, 16'h0000, 16'h0000, 16'h0000}}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  asfr_in_if  in_req ();
  asfr_out_if out_res ();

  air_sensor_frame_receiver #(
    .FRAME_LEN(FRAME_LEN)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // frame tracker state
  logic [7:0] frame_store [FRAME_LEN] = '{default: 8'h00};
  int         byte_cnt = 0;
  logic [7:0] header_reg = HEADER_RESET;

  frame_res_t pending_frames [$];
  int         error_count = 0;
  int         request_count = 0;
  int         burst_left = 0;
  logic       drv_typed = 1'b0;
  frame_res_t drv_want = '0;

  // big-endian reading; bytes at or past the checksum slot read as zero
  function automatic logic [15:0] reading_word(input int hi);
    logic [7:0] hi_b;
    logic [7:0] lo_b;
    hi_b = (hi < FRAME_LEN - 1) ? frame_store[hi] : 8'h00;
    lo_b = (hi + 1 < FRAME_LEN - 1) ? frame_store[hi + 1] : 8'h00;
    return {hi_b, lo_b};
  endfunction

  // advance the tracker by one request; an idle request yields a frame result
  function automatic void assess_request(input logic cmd, input logic [7:0] data,
                                         output logic has_frame, output frame_res_t res);
    logic [7:0] sum;
    res = '0;
    has_frame = 1'b0;
    sum = 8'h00;
    if (cmd == CMD_BYTE) begin
      if (byte_cnt < FRAME_LEN) frame_store[byte_cnt] = data;
      byte_cnt++;
      // the byte past the frame end is dropped and the count wraps
      if (byte_cnt > FRAME_LEN) byte_cnt = 0;
    end else begin
      has_frame = 1'b1;
      // length first, then header, then checksum
      if (byte_cnt != FRAME_LEN) begin
        res.status = ST_LENGTH;
      end else if (frame_store[0] != header_reg) begin
        res.status = ST_HEADER;
      end else begin
        for (int i = 0; i < FRAME_LEN - 1; i++) sum += frame_store[i];
        res.status = (sum == frame_store[FRAME_LEN - 1]) ? ST_OK : ST_SUM;
      end
      // readings stay zero on any error
      if (res.status == ST_OK) begin
        res.voc = reading_word(1);
        res.formaldehyde = reading_word(3);
        res.co2 = reading_word(5);
      end
      byte_cnt = 0;
    end
  endfunction

  function automatic void check_field(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      error_count++;
    end
  endfunction

  // result checking, request tracking and header register shadow
  always @(posedge clk) begin
    logic       has_frame;
    frame_res_t predicted;
    frame_res_t want;
    if (rst_n) begin
      if (out_res.valid && out_res.ready) begin
        if (pending_frames.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d",
                   $time, out_res.frame_status);
          error_count++;
        end else begin
          want = pending_frames.pop_front();
          check_field("frame_status", 16'(want.status), 16'(out_res.frame_status));
          check_field("voc_raw", want.voc, out_res.voc_raw);
          check_field("formaldehyde_raw", want.formaldehyde, out_res.formaldehyde_raw);
          check_field("co2_raw", want.co2, out_res.co2_raw);
        end
      end
      if (in_req.valid && in_req.ready) begin
        assess_request(in_req.command, in_req.rx_byte, has_frame, predicted);
        if (has_frame) pending_frames.push_back(drv_typed ? drv_want : predicted);
      end
      if (cfg_we) header_reg = cfg_wdata;
    end
  end

  // result side stalls on a rotating pattern, re-chosen now and then
  logic [15:0] stall_bits = 16'hFFFF;
  int          stall_left = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0: stall_bits = 16'hFFFF;
        1: stall_bits = 16'($urandom) | 16'h0001;
        2: stall_bits = 16'($urandom) | 16'($urandom) | 16'h8000;
        default: stall_bits = 16'h0001 << $urandom_range(0, 15);
      endcase
      stall_left = 16 * $urandom_range(1, 4);
    end
    out_res.ready = stall_bits[0];
    stall_bits = {stall_bits[0], stall_bits[15:1]};
    stall_left--;
  end

  // one request, sent in bursts with random gaps between them
  task automatic send_request(input logic cmd, input logic [7:0] data,
                              input logic typed, input frame_res_t want);
    @(negedge clk);
    if (burst_left == 0) begin
      in_req.valid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_req.valid = 1'b1;
    in_req.command = cmd;
    in_req.rx_byte = data;
    drv_typed = typed;
    drv_want = want;
    do @(posedge clk); while (!in_req.ready);
    burst_left--;
    request_count++;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly well-formed frames, some with bad checksum, header or length, some noise
  task automatic send_random_frame();
    logic [7:0] bytes [FRAME_LEN];
    logic [7:0] sum;
    int         kind;
    int         n;
    kind = $urandom_range(0, 99);
    sum = 8'h00;
    if (kind < 80) begin
      bytes[0] = header_reg;
      if (kind >= 70) bytes[0] = header_reg ^ 8'($urandom_range(1, 255));
      for (int i = 1; i < FRAME_LEN - 1; i++) bytes[i] = rand_byte();
      for (int i = 0; i < FRAME_LEN - 1; i++) sum += bytes[i];
      bytes[FRAME_LEN - 1] = sum;
      if (kind >= 55 && kind < 70) bytes[FRAME_LEN - 1] = sum + 8'($urandom_range(1, 255));
      for (int i = 0; i < FRAME_LEN; i++) send_request(CMD_BYTE, bytes[i], 1'b0, NO_RESULT);
      send_request(CMD_IDLE, 8'($urandom), 1'b0, NO_RESULT);
    end else if (kind < 92) begin
      // byte counts other than the frame length, including runs past the frame end
      n = $urandom_range(0, 20);
      if (n == FRAME_LEN) n++;
      repeat (n) send_request(CMD_BYTE, rand_byte(), 1'b0, NO_RESULT);
      send_request(CMD_IDLE, 8'($urandom), 1'b0, NO_RESULT);
    end else begin
      repeat ($urandom_range(1, 6))
        send_request(1'($urandom_range(0, 1)), rand_byte(), 1'b0, NO_RESULT);
    end
  endtask

  // stop sending and wait until every expected result has come
  task automatic drain_results();
    @(negedge clk);
    in_req.valid = 1'b0;
    burst_left = 0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_header(input logic [7:0] value);
    drain_results();
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [7:0] phase_headers [5];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 8'h00;
    in_req.valid = 1'b0;
    in_req.command = CMD_BYTE;
    in_req.rx_byte = 8'h00;
    phase_headers = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), HEADER_RESET};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed frames under the reset header
    foreach (DIRECTED[r])
      send_request(DIRECTED[r].command, DIRECTED[r].rx_byte, DIRECTED[r].typed,
                   DIRECTED[r].want);

    // random frames under each header setting
    foreach (phase_headers[p]) begin
      write_header(phase_headers[p]);
      request_count = 0;
      while (request_count < PHASE_REQUESTS) send_random_frame();
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: air_sensor_frame_receiver.f
rtl/core/asfr_pkg.sv
rtl/core/asfr_ifs.sv
rtl/core/asfr_collector.sv
rtl/core/air_sensor_frame_receiver.sv
tb/testbench.sv
